>>> sv/bpc_pkg.sv
// Package for the button press classifier: event codes, register indexes,
// press phase encoding, result entry type and default parameter values.
// No dependencies.
package bpc_pkg;

    // Event codes carried on the result channel.
    localparam logic [2:0] EV_CHANGE = 3'd0;
    localparam logic [2:0] EV_RESET  = 3'd1;
    localparam logic [2:0] EV_SINGLE = 3'd2;
    localparam logic [2:0] EV_DOUBLE = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_ON_LEVEL     = 3'd0;
    localparam logic [2:0] REG_INVERT       = 3'd1;
    localparam logic [2:0] REG_RESET_DETECT = 3'd2;
    localparam logic [2:0] REG_SHORT_PRESS  = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MS_W        = 16;
    localparam int UPTIME_W    = 15;
    localparam int TOGGLE_W    = 4;

    localparam logic [UPTIME_W-1:0] UPTIME_MAX = '1;

    // Defaults of the reset detection parameters.
    localparam int DEF_RESET_WINDOW_MS = 30000;
    localparam int DEF_RESET_GAP_MS    = 5000;
    localparam int DEF_RESET_TOGGLES   = 10;

    // Register reset values.
    localparam logic [MS_W-1:0] SHORT_PRESS_RST = 16'd500;
    localparam logic [MS_W-1:0] LONG_PRESS_RST  = 16'd1000;

    // Result queue geometry: one tick yields at most four results.
    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    typedef enum logic [4:0] {
        PH_IDLE            = 5'b00001,
        PH_WAIT_OFF_SINGLE = 5'b00010,
        PH_WAIT_ON_DOUBLE  = 5'b00100,
        PH_WAIT_OFF_DOUBLE = 5'b01000,
        PH_WAIT_OFF_LONG   = 5'b10000
    } bpc_phase_t;

    typedef struct packed {
        logic [2:0] code;
        logic       level;
        logic       last;
    } bpc_ev_t;

endpackage

>>> sv/button_press_classifier_core.sv
// Button press classifier top level: per-tick press classification, rapid
// toggle reset detection and a small result queue. Depends on bpc_pkg.
//
//   Channel   Direction  Ports                                   Moves
//   s_        in         s_valid/s_ready, s_pin_level            one tick sample
//   m_        out        m_valid/m_ready, m_event_code,          one event
//                        m_logical_level, m_last_event
//   cfg_      in         cfg_we, cfg_index, cfg_wdata            one register write
//
// Each accepted input transaction is fully classified in the cycle it is
// accepted; its zero to four events enter the result queue at that edge and
// leave one per cycle while m_ready is high, the earliest on the next cycle. A new tick
// is taken every cycle while the queue has room for four more events (s_ready is high
// when at most four entries are occupied). Synchronous active-low reset
// returns all registers and the press state to their power-up values and
// empties the queue. A stalled result channel only backs up the queue.
module button_press_classifier_core #(
    parameter int RESET_WINDOW_MS = bpc_pkg::DEF_RESET_WINDOW_MS,
    parameter int RESET_GAP_MS    = bpc_pkg::DEF_RESET_GAP_MS,
    parameter int RESET_TOGGLES   = bpc_pkg::DEF_RESET_TOGGLES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pin_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_event_code,
    output logic                          m_logical_level,
    output logic                          m_last_event,
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bpc_pkg::*;

    localparam logic [UPTIME_W-1:0] WINDOW = UPTIME_W'(RESET_WINDOW_MS);
    localparam logic [UPTIME_W-1:0] GAP    = UPTIME_W'(RESET_GAP_MS);
    localparam logic [TOGGLE_W-1:0] TOGGLES = TOGGLE_W'(RESET_TOGGLES);

    // Configuration registers.
    logic            on_level_reg;
    logic            invert_reg;
    logic            reset_en_reg;
    logic [MS_W-1:0] short_ms_reg;
    logic [MS_W-1:0] long_ms_reg;

    // Classifier state.
    logic                prev_raw_reg,    prev_raw_next;
    bpc_phase_t          phase_reg,       phase_next;
    logic [MS_W-1:0]     countdown_reg,   countdown_next;
    logic                running_reg,     running_next;
    logic [1:0]          expiry_reg,      expiry_next;
    logic [TOGGLE_W-1:0] toggle_reg,      toggle_next;
    logic [UPTIME_W-1:0] uptime_reg,      uptime_next;
    logic [UPTIME_W-1:0] last_change_reg, last_change_next;

    // Result queue.
    bpc_ev_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg,  count_next;

    bpc_ev_t    ev [MAX_RESULTS];
    logic [2:0] ev_n;
    logic       level;
    logic       accept;
    logic       pop;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign m_valid = count_reg != '0;

    assign m_event_code    = queue_reg[rd_ptr_reg].code;
    assign m_logical_level = queue_reg[rd_ptr_reg].level;
    assign m_last_event    = queue_reg[rd_ptr_reg].last;

    assign level = (s_pin_level == on_level_reg) ^ invert_reg;

    always_comb begin
        logic [UPTIME_W-1:0] gap_v;
        logic [MS_W-1:0]     rearm_v;

        prev_raw_next    = prev_raw_reg;
        phase_next       = phase_reg;
        countdown_next   = countdown_reg;
        running_next     = running_reg;
        expiry_next      = expiry_reg;
        toggle_next      = toggle_reg;
        last_change_next = last_change_reg;
        uptime_next      = (uptime_reg != UPTIME_MAX) ? uptime_reg + 1'b1 : uptime_reg;
        ev_n             = '0;
        gap_v            = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            ev[i] = '{code: EV_CHANGE, level: 1'b0, last: 1'b0};
        end

        // The rearm after the short interval is never shorter than one tick.
        rearm_v = (long_ms_reg > short_ms_reg) ? long_ms_reg - short_ms_reg : MS_W'(1);

        // One-shot countdown and the timer step on expiry.
        if (running_reg) begin
            if (countdown_reg != '0) begin
                countdown_next = countdown_reg - 1'b1;
            end
            if (countdown_next == '0) begin
                running_next = 1'b0;
                if (expiry_reg != 2'd3) begin
                    expiry_next = expiry_reg + 1'b1;
                end
                case (phase_reg)
                    PH_WAIT_OFF_SINGLE, PH_WAIT_OFF_DOUBLE: begin
                        countdown_next = rearm_v;
                        running_next   = 1'b1;
                        phase_next     = PH_WAIT_OFF_LONG;
                    end
                    PH_WAIT_ON_DOUBLE: begin
                        ev[ev_n[1:0]] = '{code: EV_SINGLE, level: level, last: 1'b0};
                        ev_n          = ev_n + 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    PH_WAIT_OFF_LONG: begin
                        if (expiry_next == 2'd2) begin
                            ev[ev_n[1:0]] = '{code: EV_LONG, level: level, last: 1'b0};
                            ev_n          = ev_n + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // Raw level change: change event, reset detection, press step.
        if (s_pin_level != prev_raw_reg) begin
            prev_raw_next = s_pin_level;
            ev[ev_n[1:0]] = '{code: EV_CHANGE, level: level, last: 1'b0};
            ev_n          = ev_n + 1'b1;

            if (reset_en_reg && (uptime_reg < WINDOW)) begin
                gap_v = (uptime_reg >= last_change_reg) ? uptime_reg - last_change_reg : '0;
                if (gap_v > GAP) begin
                    toggle_next = '0;
                end
                toggle_next = toggle_next + 1'b1;
                if (toggle_next >= TOGGLES) begin
                    toggle_next   = '0;
                    ev[ev_n[1:0]] = '{code: EV_RESET, level: level, last: 1'b0};
                    ev_n          = ev_n + 1'b1;
                end
            end

            case (phase_next)
                PH_WAIT_OFF_SINGLE: begin
                    if (!level) begin
                        phase_next = PH_WAIT_ON_DOUBLE;
                    end
                end
                PH_WAIT_ON_DOUBLE: begin
                    if (level) begin
                        countdown_next = (short_ms_reg == '0) ? MS_W'(1) : short_ms_reg;
                        running_next   = 1'b1;
                        expiry_next    = '0;
                        phase_next     = PH_WAIT_OFF_DOUBLE;
                    end
                end
                PH_WAIT_OFF_DOUBLE: begin
                    if (!level) begin
                        running_next  = 1'b0;
                        ev[ev_n[1:0]] = '{code: EV_DOUBLE, level: level, last: 1'b0};
                        ev_n          = ev_n + 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_WAIT_OFF_LONG: begin
                    if (!level) begin
                        running_next = 1'b0;
                        if (expiry_next == 2'd1) begin
                            ev[ev_n[1:0]] = '{code: EV_SINGLE, level: level, last: 1'b0};
                            ev_n          = ev_n + 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (level) begin
                        countdown_next = (short_ms_reg == '0) ? MS_W'(1) : short_ms_reg;
                        running_next   = 1'b1;
                        expiry_next    = '0;
                        phase_next     = PH_WAIT_OFF_SINGLE;
                    end
                end
            endcase
            last_change_next = uptime_reg;
        end

        // Flag the final event of this tick.
        if (ev_n != '0) begin
            ev[ev_n[1:0] - 2'd1].last = 1'b1;
        end
    end

    assign count_next = count_reg + (accept ? QCNT_W'(ev_n) : '0) - QCNT_W'(pop);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_level_reg <= 1'b1;
            invert_reg   <= 1'b0;
            reset_en_reg <= 1'b0;
            short_ms_reg <= SHORT_PRESS_RST;
            long_ms_reg  <= LONG_PRESS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ON_LEVEL:     on_level_reg <= cfg_wdata[0];
                REG_INVERT:       invert_reg   <= cfg_wdata[0];
                REG_RESET_DETECT: reset_en_reg <= cfg_wdata[0];
                REG_SHORT_PRESS:  short_ms_reg <= cfg_wdata;
                REG_LONG_PRESS:   long_ms_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Classifier state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg    <= 1'b0;
            phase_reg       <= PH_IDLE;
            countdown_reg   <= '0;
            running_reg     <= 1'b0;
            expiry_reg      <= '0;
            toggle_reg      <= '0;
            uptime_reg      <= '0;
            last_change_reg <= '0;
        end else if (accept) begin
            prev_raw_reg    <= prev_raw_next;
            phase_reg       <= phase_next;
            countdown_reg   <= countdown_next;
            running_reg     <= running_next;
            expiry_reg      <= expiry_next;
            toggle_reg      <= toggle_next;
            uptime_reg      <= uptime_next;
            last_change_reg <= last_change_next;
        end
    end

    // Result queue pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(ev_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Result queue storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (3'(i) < ev_n) begin
                    queue_reg[wr_ptr_reg + QPTR_W'(i)] <= ev[i];
                end
            end
        end
    end

endmodule

>>> verif/tb_button_press_classifier_core.sv
`timescale 1ns / 100ps
// Testbench for button_press_classifier_core: sends one pin sample per tick,
// predicts the press events with a behavioral model and checks them in order.
// Depends on bpc_pkg and the core.
module tb_button_press_classifier_core;
    import bpc_pkg::*;

    localparam int RANDOM_TICKS    = 380;
    localparam int RECONFIG_TICKS  = 60;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int MAX_SRC_GAP     = 6;
    localparam int DRAIN_CYCLES    = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int CYCLE_LIMIT     = 3_000_000;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                   aclk;
    logic                   aresetn         = 1'b0;
    logic                   s_valid         = 1'b0;
    logic                   s_ready;
    logic                   s_pin_level     = 1'b0;
    logic                   m_valid;
    logic                   m_ready         = 1'b0;
    logic [2:0]             m_event_code;
    logic                   m_logical_level;
    logic                   m_last_event;
    logic                   cfg_we          = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata       = '0;

    // Source and sink idling switches, and the request for a long sink stall.
    bit src_idle_on      = 1'b1;
    bit sink_idle_on     = 1'b1;
    bit hold_off_request = 1'b0;

    int fail_count  = 0;
    int ticks_sent  = 0;
    int cycle_count = 0;

    // Behavioral copy of the configuration registers, at their reset values.
    logic            mdl_on_level     = 1'b1;
    logic            mdl_invert       = 1'b0;
    logic            mdl_reset_detect = 1'b0;
    logic [MS_W-1:0] mdl_short_ms     = SHORT_PRESS_RST;
    logic [MS_W-1:0] mdl_long_ms      = LONG_PRESS_RST;

    // Behavioral copy of the press classifier state.
    logic                mdl_prev_pin    = 1'b0;
    bpc_phase_t          mdl_phase       = PH_IDLE;
    logic [MS_W-1:0]     mdl_count_ms    = '0;
    logic                mdl_count_run   = 1'b0;
    logic [1:0]          mdl_expiries    = '0;
    logic [TOGGLE_W-1:0] mdl_toggles     = '0;
    logic [UPTIME_W-1:0] mdl_uptime      = '0;
    logic [UPTIME_W-1:0] mdl_last_change = '0;

    // Events of the tick being classified, and all events still owed by the core.
    bpc_ev_t tick_events[$];
    bpc_ev_t pending_events[$];

    button_press_classifier_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pin_level     (s_pin_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_code    (m_event_code),
        .m_logical_level (m_logical_level),
        .m_last_event    (m_last_event),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Event prediction
    // ------------------------------------------------------------------

    // Arming with zero still gives a one tick countdown.
    function automatic void arm_countdown(logic [MS_W-1:0] ms);
        mdl_count_ms  = (ms == '0) ? 16'd1 : ms;
        mdl_count_run = 1'b1;
    endfunction

    // A press (first or second) starts the short press timer afresh.
    function automatic void start_press_timer();
        arm_countdown(mdl_short_ms);
        mdl_expiries = '0;
    endfunction

    function automatic void raise_event(logic [2:0] code, logic lvl);
        bpc_ev_t ev;
        if (tick_events.size() < MAX_RESULTS) begin
            ev.code  = code;
            ev.level = lvl;
            ev.last  = 1'b0;
            tick_events.push_back(ev);
        end
    endfunction

    // Classifies one accepted tick and queues the events it raises.
    function automatic void classify_tick(logic pin);
        logic                lvl;
        logic [UPTIME_W-1:0] now_ms;
        logic [UPTIME_W-1:0] gap_ms;
        lvl    = (pin == mdl_on_level) ^ mdl_invert;
        now_ms = mdl_uptime;
        tick_events.delete();

        // The countdown advances first; its expiry steps the press phase.
        if (mdl_count_run) begin
            if (mdl_count_ms != '0) mdl_count_ms = mdl_count_ms - 1'b1;
            if (mdl_count_ms == '0) begin
                mdl_count_run = 1'b0;
                if (mdl_expiries != 2'd3) mdl_expiries = mdl_expiries + 1'b1;
                case (mdl_phase)
                    PH_WAIT_OFF_SINGLE, PH_WAIT_OFF_DOUBLE: begin
                        // Rearm for the rest of the long press time, at least one tick.
                        if (mdl_long_ms > mdl_short_ms) arm_countdown(mdl_long_ms - mdl_short_ms);
                        else arm_countdown(16'd1);
                        mdl_phase = PH_WAIT_OFF_LONG;
                    end
                    PH_WAIT_ON_DOUBLE: begin
                        raise_event(EV_SINGLE, lvl);
                        mdl_phase = PH_IDLE;
                    end
                    PH_WAIT_OFF_LONG: begin
                        if (mdl_expiries == 2'd2) raise_event(EV_LONG, lvl);
                    end
                    default: ;
                endcase
            end
        end

        // A raw level change: change event, toggle counting, press phase step.
        if (pin != mdl_prev_pin) begin
            mdl_prev_pin = pin;
            raise_event(EV_CHANGE, lvl);
            if (mdl_reset_detect && now_ms < DEF_RESET_WINDOW_MS) begin
                gap_ms = (now_ms >= mdl_last_change) ? now_ms - mdl_last_change : '0;
                if (gap_ms > DEF_RESET_GAP_MS) mdl_toggles = '0;
                mdl_toggles = mdl_toggles + 1'b1;
                if (mdl_toggles >= DEF_RESET_TOGGLES) begin
                    mdl_toggles = '0;
                    raise_event(EV_RESET, lvl);
                end
            end
            case (mdl_phase)
                PH_WAIT_OFF_SINGLE: begin
                    if (!lvl) mdl_phase = PH_WAIT_ON_DOUBLE;
                end
                PH_WAIT_ON_DOUBLE: begin
                    if (lvl) begin
                        start_press_timer();
                        mdl_phase = PH_WAIT_OFF_DOUBLE;
                    end
                end
                PH_WAIT_OFF_DOUBLE: begin
                    if (!lvl) begin
                        mdl_count_run = 1'b0;
                        raise_event(EV_DOUBLE, lvl);
                        mdl_phase = PH_IDLE;
                    end
                end
                PH_WAIT_OFF_LONG: begin
                    if (!lvl) begin
                        mdl_count_run = 1'b0;
                        if (mdl_expiries == 2'd1) raise_event(EV_SINGLE, lvl);
                        mdl_phase = PH_IDLE;
                    end
                end
                default: begin
                    mdl_phase = PH_IDLE;
                    if (lvl) begin
                        start_press_timer();
                        mdl_phase = PH_WAIT_OFF_SINGLE;
                    end
                end
            endcase
            mdl_last_change = now_ms;
        end

        if (mdl_uptime != UPTIME_MAX) mdl_uptime = mdl_uptime + 1'b1;

        if (tick_events.size() != 0) tick_events[tick_events.size() - 1].last = 1'b1;
        foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
    endfunction

    // Raw pin value that gives the wanted logical level under the current polarity.
    function automatic logic pin_for(logic lvl);
        return ~(lvl ^ mdl_on_level ^ mdl_invert);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offers one tick and predicts its events once the transaction is accepted.
    // Starts and ends on a rising edge; valid stays high for a following tick.
    task automatic send_tick(input logic pin);
        int gap;
        gap = 0;
        while (src_idle_on && gap < MAX_SRC_GAP && $urandom_range(99) < 38) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= pin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        classify_tick(pin);
        ticks_sent++;
    endtask

    task automatic hold_pin(input logic pin, input int n);
        repeat (n) send_tick(pin);
    endtask

    task automatic press(input int on_ticks, input int off_ticks);
        hold_pin(pin_for(1'b1), on_ticks);
        hold_pin(pin_for(1'b0), off_ticks);
    endtask

    task automatic toggle_pin(input int n);
        repeat (n) send_tick(~mdl_prev_pin);
    endtask

    // Lets every owed event come out, then lets the core settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen with the core idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ON_LEVEL:     mdl_on_level     = val[0];
            REG_INVERT:       mdl_invert       = val[0];
            REG_RESET_DETECT: mdl_reset_detect = val[0];
            REG_SHORT_PRESS:  mdl_short_ms     = val;
            REG_LONG_PRESS:   mdl_long_ms      = val;
            default: ;
        endcase
    endtask

    // A mix of taps and holds around the configured press times.
    task automatic run_press_set();
        press(1, 3);
        press(3, 3);
        press(1, 1);
        press(1, 4);
        press(12, 4);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power-up registers: active high pin, 500 ms short and 1000 ms long press.
    task automatic test_default_registers();
        press(100, 600);   // tap, then the double window runs out: single
        press(700, 50);    // held past short, released before long: single
        press(1100, 50);   // held past long: long while still held
        press(50, 50);
        press(50, 600);    // two quick taps: double
    endtask

    // All four polarity settings; a polarity write alone raises no change.
    task automatic test_polarity();
        write_reg(REG_SHORT_PRESS, 16'd3);
        write_reg(REG_LONG_PRESS, 16'd6);
        for (int combo = 0; combo < 4; combo++) begin
            write_reg(REG_ON_LEVEL, 16'(combo & 1));
            write_reg(REG_INVERT, 16'(combo >> 1));
            hold_pin(mdl_prev_pin, 3);
            press(2, 8);
            press(9, 4);
        end
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        write_reg(REG_UNUSED_HI, 16'h0000);
        press(2, 8);
        press(1, 1);
        press(1, 8);
    endtask

    // Rapid toggling inside the reset window, with the gap limit met and missed.
    task automatic test_rapid_toggle_reset();
        write_reg(REG_SHORT_PRESS, 16'd2);
        write_reg(REG_LONG_PRESS, 16'd4);
        write_reg(REG_RESET_DETECT, 16'd1);
        toggle_pin(12);
        hold_pin(mdl_prev_pin, 20);
        // Changes exactly the gap limit apart keep counting.
        toggle_pin(4);
        hold_pin(mdl_prev_pin, DEF_RESET_GAP_MS - 1);
        toggle_pin(8);
        // One tick more and the count starts over.
        toggle_pin(3);
        hold_pin(mdl_prev_pin, DEF_RESET_GAP_MS);
        toggle_pin(10);
        // Detection off: no reset, though the time of the last change still moves.
        write_reg(REG_RESET_DETECT, 16'd0);
        toggle_pin(12);
        write_reg(REG_RESET_DETECT, 16'd1);
        toggle_pin(11);
    endtask

    // The sink stops for a long stretch while every tick raises events, so the
    // result queue fills and the input channel has to stall.
    task automatic test_back_pressure();
        hold_off_request = 1'b1;
        toggle_pin(40);
    endtask

    // Mostly well-formed presses with random timing under random settings,
    // mixed with bursts of pin noise.
    task automatic test_random_presses();
        int start_ticks;
        int next_cfg;
        int done;
        int kind;
        int dur_max;
        int n;
        start_ticks = ticks_sent;
        next_cfg    = 0;
        done        = 0;
        while (done < RANDOM_TICKS) begin
            // A stretch in the middle runs with no idling on either side.
            src_idle_on  = (done < 150) || (done >= 250);
            sink_idle_on = src_idle_on;
            if (done >= next_cfg) begin
                next_cfg += RECONFIG_TICKS;
                // Upper data bits of the one-bit registers are random and must not matter.
                write_reg(REG_ON_LEVEL, 16'($urandom));
                write_reg(REG_INVERT, 16'($urandom));
                write_reg(REG_RESET_DETECT, 16'($urandom));
                write_reg(REG_SHORT_PRESS, ($urandom_range(7) == 0) ?
                          16'($urandom_range(0, 40)) : 16'($urandom_range(1, 8)));
                write_reg(REG_LONG_PRESS, ($urandom_range(7) == 0) ?
                          16'($urandom_range(0, 40)) : 16'($urandom_range(0, 14)));
                if ($urandom_range(3) == 0)
                    write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
            end
            dur_max = (mdl_long_ms > mdl_short_ms) ? int'(mdl_long_ms) : int'(mdl_short_ms);
            if (dur_max > 21) dur_max = 21;
            dur_max += 3;
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2: press($urandom_range(1, dur_max), $urandom_range(1, dur_max));
                3, 4, 5: begin
                    press($urandom_range(1, dur_max / 2 + 1), $urandom_range(1, dur_max / 2 + 1));
                    press($urandom_range(1, dur_max), $urandom_range(1, dur_max));
                end
                6, 7: press(dur_max + $urandom_range(0, 5), $urandom_range(1, dur_max));
                default: begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_tick(1'($urandom_range(1)));
                end
            endcase
            done = ticks_sent - start_ticks;
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Ten quick changes ending just inside the reset window, then more past it.
    task automatic test_window_edge();
        int n;
        write_reg(REG_SHORT_PRESS, 16'd2);
        write_reg(REG_LONG_PRESS, 16'd4);
        write_reg(REG_RESET_DETECT, 16'd1);
        n = (DEF_RESET_WINDOW_MS - DEF_RESET_TOGGLES) - int'(mdl_uptime);
        if (n > 0) hold_pin(mdl_prev_pin, n);
        toggle_pin(20);
    endtask

    // Zero, minimal, inverted and full-scale press times.
    task automatic test_timing_extremes();
        write_reg(REG_RESET_DETECT, 16'd0);
        write_reg(REG_SHORT_PRESS, 16'd0);
        write_reg(REG_LONG_PRESS, 16'd0);
        run_press_set();
        write_reg(REG_SHORT_PRESS, 16'd1);
        write_reg(REG_LONG_PRESS, 16'd1);
        run_press_set();
        // Long below short: the rearm is raised to one tick.
        write_reg(REG_SHORT_PRESS, 16'd7);
        write_reg(REG_LONG_PRESS, 16'd3);
        run_press_set();
        write_reg(REG_SHORT_PRESS, 16'd1);
        write_reg(REG_LONG_PRESS, 16'hFFFF);
        press(3, 2);
        // Full-scale times: one press held through both expiries.
        write_reg(REG_SHORT_PRESS, 16'hFFFF);
        press(65537, 3);
    endtask

    // With the uptime stuck at its maximum, toggling can no longer reset.
    task automatic test_saturated_uptime();
        write_reg(REG_SHORT_PRESS, 16'd2);
        write_reg(REG_LONG_PRESS, 16'd4);
        write_reg(REG_RESET_DETECT, 16'd1);
        if (mdl_uptime != UPTIME_MAX) hold_pin(mdl_prev_pin, int'(UPTIME_MAX - mdl_uptime));
        toggle_pin(14);
        press(5, 5);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random idling, plus one long hold-off on request,
    // counted here in cycles while the sender keeps offering ticks.
    // ------------------------------------------------------------------
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
            end else begin
                m_ready <= sink_idle_on ? ($urandom_range(99) >= 38) : 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result transaction is compared with
    // the oldest owed event, field by field.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_events
        bpc_ev_t want;
        bpc_ev_t got;
        if (aresetn && m_valid && m_ready) begin
            got.code  = m_event_code;
            got.level = m_logical_level;
            got.last  = m_last_event;
            if (pending_events.size() == 0) begin
                report_failure($sformatf("unexpected event: code %0d level %0d last %0d",
                                         got.code, got.level, got.last));
            end else begin
                want = pending_events.pop_front();
                if (got.code != want.code || got.level != want.level ||
                    got.last != want.last)
                    report_failure($sformatf(
                        "event mismatch: expected code %0d level %0d last %0d, got %0d %0d %0d",
                        want.code, want.level, want.last, got.code, got.level, got.last));
            end
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d events still owed",
                 cycle_count, pending_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of tests. Reset detection only works in the first 30 s of
    // uptime, so everything that relies on it runs before the long holds.
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_registers();
        test_polarity();
        test_unused_index();
        test_rapid_toggle_reset();
        test_back_pressure();
        test_random_presses();
        test_window_edge();
        test_timing_extremes();
        test_saturated_uptime();

        wait_drained();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/bpc_pkg.sv
sv/button_press_classifier_core.sv
verif/tb_button_press_classifier_core.sv
